### design/r2ifft_pkg.sv
`default_nettype none
package r2ifft_pkg;
	localparam int MAX_LOG2 = 10;
	localparam logic [1:0] ACT_TW    = 2'd0;
	localparam logic [1:0] ACT_LOAD  = 2'd1;
	localparam logic [1:0] ACT_START = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;
	localparam int INT_CNT_W = 15;
	localparam int OUT_CNT_W = 12;
	localparam logic signed [63:0] ROUND_HALF = 64'sd16384;

	typedef struct packed {
		logic signed [31:0] re;
		logic signed [31:0] im;
	} wide_pair_t;

	function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
		if (v > 32'sd32767) return 16'sh7fff;
		else if (v < -32'sd32768) return 16'sh8000;
		else return v[15:0];
	endfunction

	function automatic logic sat16_hit(input logic signed [31:0] v);
		return (v > 32'sd32767) || (v < -32'sd32768);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		if (v > 35'sh0_7fff_ffff) return 32'sh7fff_ffff;
		else if (v < -35'sh0_8000_0000) return 32'sh8000_0000;
		else return v[31:0];
	endfunction

	function automatic logic sat32_hit(input logic signed [34:0] v);
		return (v > 35'sh0_7fff_ffff) || (v < -35'sh0_8000_0000);
	endfunction

	function automatic logic signed [33:0] round_q15(input logic signed [63:0] v);
		logic [63:0] mag;
		logic [63:0] q;
		mag = v[63] ? 64'(-v) : 64'(v);
		q = (mag + 64'(ROUND_HALF)) >> 15;
		return v[63] ? 34'(-q) : 34'(q);
	endfunction
endpackage
`default_nettype wire

### design/radix2_ifft_q15_unscaled_core.sv
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | action, index, in_real, in_imag
// out     | out_valid | out_stall | out_real, out_imag, internal_saturations, output_saturations
// cfg     | cfg_we    | none      | cfg_wdata
// Twiddle loads write in the accept cycle; sample loads are registered before the work
// memory write; a read result passes the address, memory read and output registers. Start
// runs bit reversal over N indices, swapping reversed pairs, then N/2*log2N butterflies and
// the output count scan, set by the one shared 32x16 multiplier and single-port work memory.
// Reset clears control, counts and result registers; memories are not cleared.
// in_stall is high while busy, while a sample write lands or while a result waits.
`default_nettype none
module radix2_ifft_q15_unscaled_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [3:0]                cfg_wdata,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [1:0]                action,
	input  wire logic [9:0]                index,
	input  wire logic signed [15:0]        in_real,
	input  wire logic signed [15:0]        in_imag,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed [15:0]             out_real,
	output logic signed [15:0]             out_imag,
	output logic [14:0]                    internal_saturations,
	output logic [11:0]                    output_saturations
);
	localparam int AW = r2ifft_pkg::MAX_LOG2;
	localparam int WD = 1 << AW;
	localparam int TD = 1 << (AW - 1);
	localparam int TW = AW - 1;
	localparam logic [3:0] MAXL = 4'(AW);

	localparam logic [4:0] S_IDLE = 5'd0, S_RD0 = 5'd1, S_RD1 = 5'd2,
		S_BR0 = 5'd3, S_BR1 = 5'd4, S_BR2 = 5'd5, S_BR3 = 5'd6,
		S_B0 = 5'd7, S_B1 = 5'd8, S_B2 = 5'd9, S_M0 = 5'd10, S_M1 = 5'd11,
		S_M2 = 5'd12, S_M3 = 5'd13, S_M4 = 5'd14, S_M5 = 5'd15,
		S_WT = 5'd16, S_WB = 5'd17, S_OC0 = 5'd18, S_OC1 = 5'd19, S_OC2 = 5'd20,
		S_BW = 5'd21;

	r2ifft_pkg::wide_pair_t work_mem [WD];
	logic [31:0] tw_mem [TD];

	logic [4:0] st_q;
	logic [3:0] l2_q;
	logic [3:0] stg_q;
	logic [AW:0] i_q;
	logic [AW-1:0] ra_q, rb_q;
	logic [AW-1:0] addr_q;
	logic we_q;
	r2ifft_pkg::wide_pair_t wdata_q, rdata_q, top_q, bot_q;
	logic [31:0] tw_rd_q;
	logic [TW-1:0] tw_a_q;
	logic [AW-1:0] p_q, blk_q;
	logic [14:0] icnt_q;
	logic [11:0] ocnt_q;
	logic [12:0] ocnt_acc_q;
	logic [15:0] icnt_acc_q;

	logic [3:0] s_used;
	logic [AW:0] n_len;
	logic [AW-1:0] half;
	logic [AW-1:0] rev;
	logic [2:0] ph;
	logic signed [31:0] ma;
	logic signed [15:0] mb;
	logic signed [33:0] rr, ri;
	r2ifft_pkg::wide_pair_t bs, bd;
	logic [3:0] bh;
	logic bypass;
	logic signed [34:0] xr, xi, yr, yi;

	assign s_used = (l2_q == 4'd0) ? 4'd1 : ((l2_q > MAXL) ? MAXL : l2_q);
	assign n_len = (AW+1)'(1) << s_used;
	assign half = AW'((AW+1)'(1) << stg_q);
	assign bypass = (p_q == '0);

	always_comb begin
		rev = '0;
		for (int b = 0; b < AW; b++)
			if (4'(b) < s_used) rev[4'(s_used - 4'd1) - 4'(b)] = i_q[b];
	end

	always_comb begin
		ph = 3'd0;
		ma = bot_q.re;
		mb = tw_rd_q[31:16];
		case (st_q)
			S_M0: begin ma = rdata_q.re; mb = tw_rd_q[31:16]; end
			S_M1: begin ma = bot_q.im; mb = tw_rd_q[15:0]; ph = 3'd1; end
			S_M2: begin ma = bot_q.im; mb = tw_rd_q[31:16]; ph = 3'd2; end
			S_M3: begin ma = bot_q.re; mb = tw_rd_q[15:0]; ph = 3'd3; end
			S_M4: ph = 3'd4;
			S_M5: ph = 3'd5;
			default: ph = 3'd0;
		endcase
	end

	r2ifft_bfly u_bfly (
		.clk(clk), .phase(ph), .bypass(bypass), .a(ma), .b(mb), .top(bot_q),
		.rr(rr), .ri(ri)
	);

	assign xr = 35'(top_q.re) + 35'(rr);
	assign xi = 35'(top_q.im) + 35'(ri);
	assign yr = 35'(top_q.re) - 35'(rr);
	assign yi = 35'(top_q.im) - 35'(ri);
	assign bs.re = r2ifft_pkg::sat32(xr);
	assign bs.im = r2ifft_pkg::sat32(xi);
	assign bd.re = r2ifft_pkg::sat32(yr);
	assign bd.im = r2ifft_pkg::sat32(yi);
	assign bh = {r2ifft_pkg::sat32_hit(xr), r2ifft_pkg::sat32_hit(xi),
		r2ifft_pkg::sat32_hit(yr), r2ifft_pkg::sat32_hit(yi)};

	always_ff @(posedge clk) begin
		if (we_q) work_mem[addr_q] <= wdata_q;
		rdata_q <= work_mem[addr_q];
		tw_rd_q <= tw_mem[tw_a_q];
		if (in_valid && !in_stall && action == r2ifft_pkg::ACT_TW)
			tw_mem[index[TW-1:0]] <= {in_real, in_imag};
	end

	logic [2:0] nh;
	assign nh = 3'(bh[0]) + 3'(bh[1]) + 3'(bh[2]) + 3'(bh[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			l2_q <= 4'd10;
			out_valid <= 1'b0;
			we_q <= 1'b0;
			icnt_q <= '0;
			ocnt_q <= '0;
			stg_q <= '0;
			i_q <= '0;
			ra_q <= '0;
			rb_q <= '0;
			addr_q <= '0;
			wdata_q <= '0;
			top_q <= '0;
			bot_q <= '0;
			tw_a_q <= '0;
			p_q <= '0;
			blk_q <= '0;
			ocnt_acc_q <= '0;
			icnt_acc_q <= '0;
			out_real <= '0;
			out_imag <= '0;
			internal_saturations <= '0;
			output_saturations <= '0;
		end else begin
			if (cfg_we) l2_q <= cfg_wdata;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			we_q <= 1'b0;
			case (st_q)
				S_IDLE: if (in_valid && !in_stall) begin
					case (action)
						r2ifft_pkg::ACT_LOAD: begin
							addr_q <= index[AW-1:0];
							wdata_q.re <= 32'(in_real);
							wdata_q.im <= 32'(in_imag);
							we_q <= 1'b1;
						end
						r2ifft_pkg::ACT_READ: begin
							addr_q <= index[AW-1:0];
							st_q <= S_RD0;
						end
						r2ifft_pkg::ACT_START: begin
							i_q <= '0;
							st_q <= S_BR0;
						end
						default: ;
					endcase
				end
				S_RD0: st_q <= S_RD1;
				S_RD1: begin
					out_real <= r2ifft_pkg::sat16(rdata_q.re);
					out_imag <= r2ifft_pkg::sat16(rdata_q.im);
					internal_saturations <= icnt_q;
					output_saturations <= ocnt_q;
					out_valid <= 1'b1;
					st_q <= S_IDLE;
				end
				S_BR0: begin
					if (i_q == n_len) begin
						stg_q <= '0; blk_q <= '0; p_q <= '0; icnt_acc_q <= '0;
						st_q <= S_B0;
					end else if (AW'(rev) > i_q[AW-1:0]) begin
						ra_q <= i_q[AW-1:0]; rb_q <= rev;
						addr_q <= i_q[AW-1:0]; st_q <= S_BR1;
					end else i_q <= i_q + 1'b1;
				end
				S_BR1: begin addr_q <= rb_q; st_q <= S_BR2; end
				S_BR2: begin top_q <= rdata_q; st_q <= S_BR3; end
				S_BR3: begin
					addr_q <= ra_q; wdata_q <= rdata_q; we_q <= 1'b1;
					st_q <= S_BW; bot_q <= top_q; i_q <= i_q + 1'b1;
				end
				S_BW: begin
					addr_q <= rb_q; wdata_q <= bot_q; we_q <= 1'b1;
					st_q <= S_BR0;
				end
				S_B0: begin
					if ({1'b0, stg_q} == {1'b0, s_used}) begin
						i_q <= '0; ocnt_acc_q <= '0;
						icnt_q <= (icnt_acc_q > 16'd32767) ? 15'h7fff : icnt_acc_q[14:0];
						addr_q <= '0; st_q <= S_OC0;
					end else begin
						ra_q <= blk_q + p_q; rb_q <= blk_q + p_q + half;
						addr_q <= blk_q + p_q;
						tw_a_q <= TW'(p_q << (s_used - 4'd1 - stg_q));
						st_q <= S_B1;
					end
				end
				S_B1: begin addr_q <= rb_q; st_q <= S_B2; end
				S_B2: begin top_q <= rdata_q; st_q <= S_M0; end
				S_M0: begin bot_q <= rdata_q; st_q <= S_M1; end
				S_M1: st_q <= S_M2;
				S_M2: st_q <= S_M3;
				S_M3: st_q <= S_M4;
				S_M4: st_q <= S_M5;
				S_M5: st_q <= S_WT;
				S_WT: begin
					addr_q <= ra_q; wdata_q <= bs; we_q <= 1'b1;
					bot_q <= bd;
					icnt_acc_q <= icnt_acc_q + 16'(nh);
					st_q <= S_WB;
				end
				S_WB: begin
					addr_q <= rb_q; wdata_q <= bot_q; we_q <= 1'b1;
					if (p_q + 1'b1 == half) begin
						p_q <= '0;
						if ((AW+1)'(blk_q) + (AW+1)'(half) + (AW+1)'(half) >= n_len) begin
							blk_q <= '0; stg_q <= stg_q + 1'b1;
						end else blk_q <= blk_q + half + half;
					end else p_q <= p_q + 1'b1;
					st_q <= S_B0;
				end
				S_OC0: begin addr_q <= addr_q + 1'b1; st_q <= S_OC1; end
				S_OC1: begin
					ocnt_acc_q <= ocnt_acc_q + 13'(r2ifft_pkg::sat16_hit(rdata_q.re))
						+ 13'(r2ifft_pkg::sat16_hit(rdata_q.im));
					i_q <= i_q + 1'b1;
					addr_q <= addr_q + 1'b1;
					if (i_q + 1'b1 == n_len) st_q <= S_OC2;
				end
				S_OC2: begin
					out_real <= '0; out_imag <= '0;
					internal_saturations <= icnt_q;
					ocnt_q <= (ocnt_acc_q > 13'd4095) ? 12'hfff : ocnt_acc_q[11:0];
					output_saturations <= (ocnt_acc_q > 13'd4095) ? 12'hfff : ocnt_acc_q[11:0];
					out_valid <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall = (st_q != S_IDLE) || out_valid || we_q;
endmodule
`default_nettype wire

### design/r2ifft_bfly.sv
`default_nettype none
module r2ifft_bfly (
	input  wire logic                 clk,
	input  wire logic [2:0]           phase,
	input  wire logic                 bypass,
	input  wire logic signed [31:0]   a,
	input  wire logic signed [15:0]   b,
	input  wire r2ifft_pkg::wide_pair_t top,
	output logic signed [33:0]        rr,
	output logic signed [33:0]        ri
);
	logic signed [47:0] prod_q;
	logic signed [63:0] acc_q;
	logic signed [33:0] rr_q, ri_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
		case (phase)
			3'd1: acc_q <= 64'(prod_q);
			3'd2: acc_q <= acc_q + 64'(prod_q);
			3'd3: begin
				rr_q <= r2ifft_pkg::round_q15(acc_q);
				acc_q <= 64'(prod_q);
			end
			3'd4: acc_q <= acc_q - 64'(prod_q);
			3'd5: ri_q <= r2ifft_pkg::round_q15(acc_q);
			default: acc_q <= acc_q;
		endcase
	end

	always_comb begin
		rr = bypass ? 34'(top.re) : rr_q;
		ri = bypass ? 34'(top.im) : ri_q;
	end
endmodule
`default_nettype wire

### design/r2ifft_check.sv
`default_nettype none
module r2ifft_check (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic [1:0] action,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic signed [15:0] out_real
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_real))
		else $error("result dropped while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result waits");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action != r2ifft_pkg::ACT_TW |=> in_stall)
		else $error("back to back accept");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({out_valid, in_stall}))
		else $error("handshake unknown");
endmodule
bind radix2_ifft_q15_unscaled_core r2ifft_check u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.action(action), .out_valid(out_valid), .out_stall(out_stall), .out_real(out_real)
);
`default_nettype wire
